/* rtl/hidkbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkbd_pkg
// Shared types and constants for the boot keyboard new key detector.
// ----------------------------------------------------------------------------
package hidkbd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int KEY_W     = 8;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = $clog2(KEY_SLOTS);
    localparam int CNT_W     = $clog2(KEY_SLOTS + 1);
    localparam int NEW_W     = 2;

    typedef logic [KEY_W-1:0]                 key_t;
    typedef logic [KIND_W-1:0]                kind_t;
    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0]  key_vec_t;
    typedef logic [CNT_W-1:0]                 cnt_t;
    typedef logic [NEW_W-1:0]                 new_cnt_t;

    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_DOWN  = 2'd1;
    localparam kind_t KIND_ERROR = 2'd2;

    localparam key_t KEY_NONE       = 8'h00;
    localparam key_t KEY_ROLLOVER   = 8'h01;
    localparam key_t KEY_POST_FAIL  = 8'h02;
    localparam key_t KEY_UNDEFINED  = 8'h03;

    localparam new_cnt_t NEW_ZERO = 2'd0;
    localparam new_cnt_t NEW_ONE  = 2'd1;
    localparam new_cnt_t NEW_MANY = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

    function automatic logic is_error_code(input key_t k);
        return k inside {KEY_ROLLOVER, KEY_POST_FAIL, KEY_UNDEFINED};
    endfunction

endpackage

/* rtl/hid_keyboard_new_key_detect_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_new_key_detect_core
// Boot keyboard report new key detector.
//
// The s_ channel takes one report per request: the modifier byte and six
// keycode slots. The m_ channel gives exactly one result per report: no
// event, a single new key down with its keycode and modifiers, or an error
// when a slot holds a rollover or error code (state left as it was).
// A request is taken only while the sequencer is idle. The datapath then
// walks the slots one per cycle, comparing each against the remembered
// key list in parallel, and commits once the output register is free.
// The result is registered at the commit; a new request can be taken in
// the cycle after the commit, so no new report is taken before the commit.
// The output register holds the result while the receiver stalls, and the
// next report is processed meanwhile; the commit then waits for the
// output register to drain.
// Reset clears the remembered key count and the output valid.
// ----------------------------------------------------------------------------
module hid_keyboard_new_key_detect_core
    import hidkbd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  key_t  s_modifiers,
    input  key_t  s_key_0,
    input  key_t  s_key_1,
    input  key_t  s_key_2,
    input  key_t  s_key_3,
    input  key_t  s_key_4,
    input  key_t  s_key_5,
    output logic  m_valid,
    input  logic  m_ready,
    output kind_t m_event_kind,
    output key_t  m_new_keycode,
    output key_t  m_event_modifiers
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    key_vec_t     in_keys;

    assign in_keys = {s_key_5, s_key_4, s_key_3, s_key_2, s_key_1, s_key_0};

    hidkbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hidkbd_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_modifiers      (s_modifiers),
        .in_keys           (in_keys),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_new_keycode     (m_new_keycode),
        .m_event_modifiers (m_event_modifiers)
    );

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind != KIND_DOWN) |->
            (m_new_keycode == KEY_NONE) && (m_event_modifiers == KEY_NONE))
        else $error("payload not cleared for non key-down result");

    a_down_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_DOWN) |->
            (m_new_keycode != KEY_NONE) && !is_error_code(m_new_keycode))
        else $error("key-down result carries empty or error keycode");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind == KIND_NONE) || (m_event_kind == KIND_DOWN) ||
            (m_event_kind == KIND_ERROR))
        else $error("bad event kind");

endmodule

/* rtl/hidkbd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkbd_ctrl
// Sequencer: takes a request, steps the datapath over each slot, then
// commits the result once the output register is free.
// ----------------------------------------------------------------------------
module hidkbd_ctrl
    import hidkbd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/hidkbd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkbd_datapath
// Slot shifter, held-key list builder, previous-key compare and the
// output register.
// ----------------------------------------------------------------------------
module hidkbd_datapath
    import hidkbd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    input  key_t         in_modifiers,
    input  key_vec_t     in_keys,
    output logic         m_valid,
    input  logic         m_ready,
    output kind_t        m_event_kind,
    output key_t         m_new_keycode,
    output key_t         m_event_modifiers
);

    key_vec_t slot_reg;
    key_vec_t held_reg;
    key_vec_t prev_keys_reg;
    cnt_t     prev_count_reg;
    cnt_t     held_cnt_reg;
    new_cnt_t new_n_reg;
    key_t     first_new_reg;
    key_t     mods_reg;
    logic     err_reg;
    logic     m_valid_reg;
    kind_t    kind_reg;
    key_t     keycode_reg;
    key_t     out_mods_reg;

    key_t cur_key;
    logic hit;
    logic in_err;

    assign cur_key = slot_reg[0];
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        in_err = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (is_error_code(in_keys[i])) begin
                in_err = 1'b1;
            end
        end
    end

    // match against the remembered list, only entries below the count
    always_comb begin
        hit = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if ((CNT_W'(j) < prev_count_reg) && (prev_keys_reg[j] == cur_key)) begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            slot_reg     <= in_keys;
            held_reg     <= '0;
            held_cnt_reg <= '0;
            new_n_reg    <= NEW_ZERO;
            mods_reg     <= in_modifiers;
            err_reg      <= in_err;
        end else if (cmd.step) begin
            slot_reg <= {KEY_NONE, slot_reg[KEY_SLOTS-1:1]};
            if (cur_key != KEY_NONE) begin
                held_reg[held_cnt_reg[IDX_W-1:0]] <= cur_key;
                held_cnt_reg <= held_cnt_reg + CNT_W'(1);
                if (!hit) begin
                    if (new_n_reg == NEW_ZERO) begin
                        first_new_reg <= cur_key;
                    end
                    if (new_n_reg != NEW_MANY) begin
                        new_n_reg <= new_n_reg + NEW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (err_reg) begin
                kind_reg     <= KIND_ERROR;
                keycode_reg  <= KEY_NONE;
                out_mods_reg <= KEY_NONE;
            end else begin
                prev_keys_reg <= held_reg;
                if (new_n_reg == NEW_ONE) begin
                    kind_reg     <= KIND_DOWN;
                    keycode_reg  <= first_new_reg;
                    out_mods_reg <= mods_reg;
                end else begin
                    kind_reg     <= KIND_NONE;
                    keycode_reg  <= KEY_NONE;
                    out_mods_reg <= KEY_NONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                if (!err_reg) begin
                    prev_count_reg <= held_cnt_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_event_kind      = kind_reg;
    assign m_new_keycode     = keycode_reg;
    assign m_event_modifiers = out_mods_reg;

endmodule

/* tb/hid_keyboard_new_key_detect_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_new_key_detect_core_tb
// Self-checking bench for the boot keyboard new key detector.
//
// Reports go in on the s_ channel and one event per report comes back on
// the m_ channel. A local model keeps its own copy of the remembered key
// list and predicts each event when its request is taken. A short table
// covers the edge cases: error codes, empty reports, full reports, chords
// and repeated keycodes. Random keyboard-like sessions follow, with
// presses, releases, chords and error reports plus some raw noise. Both
// sides stall at random in changing proportions. The final phase has no
// stalls.
// ----------------------------------------------------------------------------
module hid_keyboard_new_key_detect_core_tb;
    import hidkbd_pkg::*;

    localparam int DIRECTED_ROWS  = 23;
    localparam int RANDOM_REPORTS = 1030;
    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        key_t     mods;
        key_vec_t keys;
    } report_t;

    typedef struct packed {
        kind_t kind;
        key_t  keycode;
        key_t  mods;
    } key_event_t;

    typedef struct packed {
        key_t  mods;
        key_t  k0;
        key_t  k1;
        key_t  k2;
        key_t  k3;
        key_t  k4;
        key_t  k5;
        bit    typed;
        kind_t kind;
        key_t  code;
        key_t  emods;
    } stim_row_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    key_t  s_modifiers = KEY_NONE;
    key_t  s_key_0 = KEY_NONE;
    key_t  s_key_1 = KEY_NONE;
    key_t  s_key_2 = KEY_NONE;
    key_t  s_key_3 = KEY_NONE;
    key_t  s_key_4 = KEY_NONE;
    key_t  s_key_5 = KEY_NONE;
    logic  m_valid;
    logic  m_ready = 1'b0;
    kind_t m_event_kind;
    key_t  m_new_keycode;
    key_t  m_event_modifiers;

    key_t       held_keys [KEY_SLOTS];
    int         held_count = 0;
    key_event_t pending_key_events [$];
    int         fail_count = 0;
    int         stall_cycles = 0;
    int         send_idle_pct = 29;
    int         recv_idle_pct = 58;

    // mods, slots 0..5, typed, kind, keycode, event modifiers
    stim_row_t report_rows [DIRECTED_ROWS] = '{
        '{8'hA5, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DOWN, 8'h04, 8'hA5},
        '{8'h3C, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'hFF, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, KIND_DOWN, 8'hFF, 8'hFF},
        '{8'h11, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, KIND_ERROR, 8'h00, 8'h00},
        '{8'h22, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 1'b1, KIND_ERROR, 8'h00, 8'h00},
        '{8'h33, 8'h04, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03, 1'b1, KIND_ERROR, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h04, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        '{8'h01, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        '{8'h02, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h08, 8'h0C, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h10, 8'h0C, 8'h0C, 8'h0D, 8'h00, 8'h00, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h20, 8'h00, 8'h00, 8'h04, 8'h00, 8'h0C, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h7F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 1'b1, KIND_DOWN, 8'h80, 8'h00},
        '{8'hFE, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'h01, 8'hFB, 1'b1, KIND_ERROR, 8'h00, 8'h00},
        '{8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 1'b0, KIND_NONE, 8'h00, 8'h00},
        '{8'h55, 8'h04, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_ERROR, 8'h00, 8'h00},
        '{8'h55, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_NONE, 8'h00, 8'h00}
    };

    hid_keyboard_new_key_detect_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_modifiers       (s_modifiers),
        .s_key_0           (s_key_0),
        .s_key_1           (s_key_1),
        .s_key_2           (s_key_2),
        .s_key_3           (s_key_3),
        .s_key_4           (s_key_4),
        .s_key_5           (s_key_5),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_new_keycode     (m_new_keycode),
        .m_event_modifiers (m_event_modifiers)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic key_event_t predict_key_event(input report_t rpt);
        key_event_t ev;
        key_t       now_keys [KEY_SLOTS];
        int         now_count;
        int         fresh_count;
        bit         known;
        ev = '{KIND_NONE, KEY_NONE, KEY_NONE};
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (rpt.keys[i] inside {KEY_ROLLOVER, KEY_POST_FAIL, KEY_UNDEFINED}) begin
                ev.kind = KIND_ERROR;
                return ev;
            end
        end
        now_count = 0;
        fresh_count = 0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            now_keys[i] = KEY_NONE;
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (rpt.keys[i] != KEY_NONE) begin
                known = 1'b0;
                for (int j = 0; j < held_count; j++) begin
                    if (held_keys[j] == rpt.keys[i]) begin
                        known = 1'b1;
                    end
                end
                now_keys[now_count] = rpt.keys[i];
                now_count++;
                if (!known) begin
                    if (fresh_count == 0) begin
                        ev.keycode = rpt.keys[i];
                    end
                    fresh_count++;
                end
            end
        end
        if (fresh_count == 1) begin
            ev.kind = KIND_DOWN;
            ev.mods = rpt.mods;
        end else begin
            ev.keycode = KEY_NONE;
        end
        held_keys = now_keys;
        held_count = now_count;
        return ev;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_report(input report_t rpt, input bit typed, input key_event_t typed_ev);
        key_event_t ev;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_modifiers <= rpt.mods;
        s_key_0     <= rpt.keys[0];
        s_key_1     <= rpt.keys[1];
        s_key_2     <= rpt.keys[2];
        s_key_3     <= rpt.keys[3];
        s_key_4     <= rpt.keys[4];
        s_key_5     <= rpt.keys[5];
        do @(posedge aclk); while (!s_ready);
        ev = predict_key_event(rpt);
        if (typed) begin
            ev = typed_ev;
        end
        pending_key_events.push_back(ev);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_key_events.size() != 0) @(posedge aclk);
    endtask

    // receiver side: check each event and pick the next ready
    always @(posedge aclk) begin
        key_event_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_key_events.size() == 0) begin
                    $display("%0t ns: event with no request pending, got kind 0x%0h",
                             $time, m_event_kind);
                    fail_count++;
                end else begin
                    want = pending_key_events.pop_front();
                    check_field("event_kind", want.kind, m_event_kind);
                    check_field("new_keycode", want.keycode, m_new_keycode);
                    check_field("event_modifiers", want.mods, m_event_modifiers);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        report_t    rpt;
        stim_row_t  row;
        key_event_t ev;
        key_t       pool [$];
        int         action;
        int         slot;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (report_rows[r]) begin
            row = report_rows[r];
            rpt.mods = row.mods;
            rpt.keys[0] = row.k0;
            rpt.keys[1] = row.k1;
            rpt.keys[2] = row.k2;
            rpt.keys[3] = row.k3;
            rpt.keys[4] = row.k4;
            rpt.keys[5] = row.k5;
            ev = '{row.kind, row.code, row.emods};
            send_report(rpt, row.typed, ev);
        end

        ev = '{KIND_NONE, KEY_NONE, KEY_NONE};
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            if (n == RANDOM_REPORTS / 3) begin
                drain_results();
                send_idle_pct = 58;
                recv_idle_pct = 29;
            end else if (n == 2 * RANDOM_REPORTS / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pool = {};
            for (int j = 0; j < held_count; j++) begin
                pool.push_back(held_keys[j]);
            end
            action = $urandom_range(99);
            rpt.mods = key_t'($urandom_range(255));
            rpt.keys = '0;
            if (action < 34) begin
                if (pool.size() < KEY_SLOTS) begin
                    pool.push_back(key_t'($urandom_range(255, 4)));
                end
            end else if (action < 52) begin
                if (pool.size() != 0) begin
                    pool.delete($urandom_range(pool.size() - 1));
                end
            end else if (action < 60) begin
                // chord, the second key sometimes a repeat of the first
                if (pool.size() < KEY_SLOTS) begin
                    pool.push_back(key_t'($urandom_range(255, 4)));
                end
                if (pool.size() < KEY_SLOTS && pool.size() != 0) begin
                    if ($urandom_range(1)) begin
                        pool.push_back(pool[pool.size() - 1]);
                    end else begin
                        pool.push_back(key_t'($urandom_range(255, 4)));
                    end
                end
            end else if (action < 66) begin
                pool = {};
            end
            if (action < 86) begin
                foreach (pool[j]) begin
                    do slot = $urandom_range(KEY_SLOTS - 1); while (rpt.keys[slot] != KEY_NONE);
                    rpt.keys[slot] = pool[j];
                end
                if (action >= 72) begin
                    slot = $urandom_range(KEY_SLOTS - 1);
                    case ($urandom_range(2))
                        0: rpt.keys[slot] = KEY_ROLLOVER;
                        1: rpt.keys[slot] = KEY_POST_FAIL;
                        default: rpt.keys[slot] = KEY_UNDEFINED;
                    endcase
                end
            end else begin
                for (int j = 0; j < KEY_SLOTS; j++) begin
                    rpt.keys[j] = $urandom_range(1) ? key_t'($urandom_range(255)) : KEY_NONE;
                end
            end
            send_report(rpt, 1'b0, ev);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/hidkbd_pkg.sv
rtl/hidkbd_ctrl.sv
rtl/hidkbd_datapath.sv
rtl/hid_keyboard_new_key_detect_core.sv
tb/hid_keyboard_new_key_detect_core_tb.sv
